### rtl/core/vtps_pkg.sv
// ----------------------------------------------------------------------------
// vtps_pkg
// Shared widths, codes and types of the video tile packet segmenter.
// ----------------------------------------------------------------------------
package vtps_pkg;

  // default sizes
  localparam int DEF_MAX_STREAMS   = 10;
  localparam int DEF_HEADER_BYTES  = 64;
  localparam int DEF_PAYLOAD_ALIGN = 48;

  // field widths
  localparam int MTU_W      = 14;
  localparam int CS_W       = 4;
  localparam int LEN_W      = 28;
  localparam int OFS_W      = 29;
  localparam int SUB_W      = 10;
  localparam int PLEN_W     = 14;
  localparam int COPIES_W   = 3;
  localparam int TAG_W      = 22;
  localparam int HDR_W      = 32;
  localparam int LEAD_W     = 4;
  localparam int VISIT_W    = 6;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 14;
  localparam logic [CFG_IDX_W-1:0] CFG_MTU_BYTES       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REDUNDANCY_MODE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COPY_STREAMS    = 2'd2;

  // register reset values
  localparam logic [MTU_W-1:0] MTU_RESET    = 14'd1500;
  localparam logic [CS_W-1:0]  COPIES_RESET = 4'd1;

  // item codes
  localparam logic MODE_LOAD    = 1'b0;
  localparam logic MODE_REQUEST = 1'b1;

  // copy counts and limits
  localparam logic [COPIES_W-1:0] COPIES_SINGLE = 3'd1;
  localparam logic [COPIES_W-1:0] COPIES_MARKED = 3'd6;
  localparam logic [LEAD_W-1:0]   LEAD_MAX      = 4'hf;
  localparam logic [VISIT_W-1:0]  VISIT_LAST    = 6'd63;

  // chunk size from the size unit
  typedef struct packed {
    logic             settled;
    logic [PLEN_W-1:0] size;
  } chunk_t;

endpackage

### rtl/core/vtps_in_if.sv
// ----------------------------------------------------------------------------
// vtps_in_if
// Input channel: tile loads and packet requests.
// ----------------------------------------------------------------------------
interface vtps_in_if;
  import vtps_pkg::*;

  logic             valid;
  logic             ready;
  logic             mode;
  logic [LEN_W-1:0] tile_length;
  logic [LEN_W-1:0] byte_offset;
  logic [SUB_W-1:0] substream;
  logic             send_marker;

  modport source (
    output valid, mode, tile_length, byte_offset, substream, send_marker,
    input  ready
  );

  modport sink (
    input  valid, mode, tile_length, byte_offset, substream, send_marker,
    output ready
  );
endinterface

### rtl/core/vtps_out_if.sv
// ----------------------------------------------------------------------------
// vtps_out_if
// Output channel: packet descriptors.
// ----------------------------------------------------------------------------
interface vtps_out_if;
  import vtps_pkg::*;

  logic                valid;
  logic                ready;
  logic                packet_valid;
  logic [OFS_W-1:0]    packet_offset;
  logic [LEN_W-1:0]    payload_start;
  logic [PLEN_W-1:0]   payload_length;
  logic                marker;
  logic [COPIES_W-1:0] copies;
  logic [HDR_W-1:0]    header_tag_word;
  logic                tile_done;

  modport source (
    output valid, packet_valid, packet_offset, payload_start, payload_length,
           marker, copies, header_tag_word, tile_done,
    input  ready
  );

  modport sink (
    input  valid, packet_valid, packet_offset, payload_start, payload_length,
           marker, copies, header_tag_word, tile_done,
    output ready
  );
endinterface

### rtl/core/vtps_chunk.sv
// ----------------------------------------------------------------------------
// vtps_chunk
// Payload size per packet: (mtu - header) rounded down to the alignment,
// never below one alignment unit. Two register stages, reciprocal multiply.
// ----------------------------------------------------------------------------
module vtps_chunk #(
  parameter int HEADER_BYTES  = vtps_pkg::DEF_HEADER_BYTES,
  parameter int PAYLOAD_ALIGN = vtps_pkg::DEF_PAYLOAD_ALIGN
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        mtu_write,
  input  logic [vtps_pkg::MTU_W-1:0]  mtu,
  output vtps_pkg::chunk_t            chunk
);
  import vtps_pkg::*;

  // exact floor division for any value below 2^MTU_W
  localparam int ShiftBits = MTU_W + $clog2(PAYLOAD_ALIGN);
  localparam int ProdW     = MTU_W + ShiftBits + 1;
  localparam longint RecipL = ((64'(1) << ShiftBits) + PAYLOAD_ALIGN - 1) / PAYLOAD_ALIGN;
  localparam logic [ShiftBits:0] Recip = (ShiftBits + 1)'(RecipL);

  logic [MTU_W-1:0] avail;
  logic [ProdW-1:0] prod;
  logic [MTU_W-1:0] quot;
  logic [MTU_W-1:0] rounded;
  logic [MTU_W-1:0] size;
  logic [1:0]       settle;

  // bytes left after the header
  assign avail = (mtu > MTU_W'(HEADER_BYTES)) ? (mtu - MTU_W'(HEADER_BYTES)) : '0;

  // stage one: quotient by reciprocal
  always_ff @(posedge clk) begin
    prod <= ProdW'(avail) * ProdW'(Recip);
  end

  assign quot    = prod[ShiftBits +: MTU_W];
  assign rounded = MTU_W'(quot * MTU_W'(PAYLOAD_ALIGN));

  // stage two: back to bytes, tiny unit gets one alignment unit
  always_ff @(posedge clk) begin
    size <= (rounded == '0) ? MTU_W'(PAYLOAD_ALIGN) : rounded;
  end

  // settled is held low after an mtu write until the new mtu has passed through both register stages
  always_ff @(posedge clk) begin
    if (rst || mtu_write) begin
      settle <= 2'd2;
    end else if (settle != 2'd0) begin
      settle <= settle - 2'd1;
    end
  end

  assign chunk.settled = (settle == 2'd0);
  assign chunk.size    = PLEN_W'(size);
endmodule

### rtl/core/video_tile_packet_segmenter.sv
// ----------------------------------------------------------------------------
// video_tile_packet_segmenter
// Cuts a loaded video tile into packet descriptors, one per request, with
// interleaved copy streams and a latched frame-end marker.
// ----------------------------------------------------------------------------
//  port      dir  handshake      carries
//  tile_in   in   valid/ready    load (mode 0) or packet request (mode 1)
//  pkt_out   out  valid/ready    one packet descriptor per request
//  cfg_*     in   write enable   mtu_bytes, redundancy_mode, copy_streams
//
//  A load is taken on entry. A request enters and then makes stream visits on
//  the shared add/compare unit: 1 visit normally, more when finished streams
//  yield no bytes and are passed over, bounded by the visit limit VISIT_LAST.
//  After an mtu write, input waits while the chunk size settles.
//  rst is synchronous; a result held in the output register does not stop a
//  load or the next request from entering, only a request's last step waits on it.
// ----------------------------------------------------------------------------
module video_tile_packet_segmenter #(
  parameter int MAX_STREAMS   = vtps_pkg::DEF_MAX_STREAMS,
  parameter int HEADER_BYTES  = vtps_pkg::DEF_HEADER_BYTES,
  parameter int PAYLOAD_ALIGN = vtps_pkg::DEF_PAYLOAD_ALIGN
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [vtps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [vtps_pkg::CFG_DATA_W-1:0] cfg_data,
  vtps_in_if.sink                         tile_in,
  vtps_out_if.source                      pkt_out
);
  import vtps_pkg::*;

  localparam int SidxW = (MAX_STREAMS > 1) ? $clog2(MAX_STREAMS) : 1;
  localparam int CntW  = $clog2(MAX_STREAMS + 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  // configuration registers
  logic [MTU_W-1:0] mtu_bytes;
  logic             redundancy_mode;
  logic [CS_W-1:0]  copy_streams;

  // tile state
  logic [LEN_W-1:0]       stream_position [MAX_STREAMS];
  logic [MAX_STREAMS-1:0] stream_fin;
  logic [SidxW-1:0]       turn_index;
  logic [LEAD_W-1:0]      lead_count;
  logic [LEN_W-1:0]       tile_bytes;
  logic [LEN_W-1:0]       tile_offset_base;
  logic [SUB_W-1:0]       tile_substream;
  logic                   marker_allowed;
  logic                   marker_latched;
  logic                   tile_active;
  logic [TAG_W-1:0]       tile_tag;

  logic                   state;
  logic [VISIT_W-1:0]     visit_count;

  // output register
  logic                   out_full;
  logic                   out_free;

  chunk_t                 chunk;
  logic                   in_take;
  logic                   mtu_write;

  // visit datapath
  logic [CntW-1:0]        k;
  logic [SidxW-1:0]       last_idx;
  logic [SidxW-1:0]       idx;
  logic [SidxW-1:0]       idx_next;
  logic [LEN_W-1:0]       start;
  logic [LEN_W:0]         sum;
  logic                   clamp;
  logic [LEN_W-1:0]       end_pos;
  logic [PLEN_W-1:0]      dl;
  logic [LEAD_W-1:0]      lead_next;
  logic                   advance;
  logic                   done;
  logic                   brk;
  logic                   visit_fire;
  logic                   emit;
  logic                   latched_next;

  // chunk size unit
  assign mtu_write = cfg_we && (cfg_index == CFG_MTU_BYTES);

  vtps_chunk #(
    .HEADER_BYTES  (HEADER_BYTES),
    .PAYLOAD_ALIGN (PAYLOAD_ALIGN)
  ) u_chunk (
    .clk       (clk),
    .rst       (rst),
    .mtu_write (mtu_write),
    .mtu       (mtu_bytes),
    .chunk     (chunk)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      mtu_bytes       <= MTU_RESET;
      redundancy_mode <= 1'b0;
      copy_streams    <= COPIES_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MTU_BYTES:       mtu_bytes       <= cfg_data[MTU_W-1:0];
        CFG_REDUNDANCY_MODE: redundancy_mode <= cfg_data[0];
        CFG_COPY_STREAMS:    copy_streams    <= cfg_data[CS_W-1:0];
        default: ;
      endcase
    end
  end

  // active stream count
  always_comb begin
    if (!redundancy_mode || (copy_streams == '0)) begin
      k = CntW'(1);
    end else if (int'(copy_streams) > MAX_STREAMS) begin
      k = CntW'(MAX_STREAMS);
    end else begin
      k = CntW'(copy_streams);
    end
  end

  assign last_idx = SidxW'(k - CntW'(1));
  assign idx      = (CntW'(turn_index) < k) ? turn_index : '0;

  // one stream visit on the shared adder
  assign start   = stream_position[idx];
  assign sum     = {1'b0, start} + (LEN_W + 1)'(chunk.size);
  assign clamp   = (sum >= {1'b0, tile_bytes});
  assign end_pos = clamp ? tile_bytes : sum[LEN_W-1:0];
  assign dl      = clamp ? PLEN_W'(tile_bytes - start) : chunk.size;

  assign lead_next = (lead_count != LEAD_MAX) ? (lead_count + LEAD_W'(1)) : lead_count;
  assign advance   = (idx != '0) || ((int'(lead_next) + 1) >= int'(k));

  always_comb begin
    idx_next = idx;
    if (advance) begin
      idx_next = ((CntW'(idx) + CntW'(1)) == k) ? '0 : (idx + SidxW'(1));
    end
  end

  // last stream finished after this visit
  assign done = (idx == last_idx) ? clamp : stream_fin[last_idx];
  assign brk  = (dl != '0) || done || (visit_count == VISIT_LAST);

  assign latched_next = marker_latched || (clamp && marker_allowed);

  assign out_free   = !out_full || pkt_out.ready;
  assign visit_fire = (state == ST_RUN) && tile_active && (!brk || out_free);
  assign emit       = (state == ST_RUN) && out_free && (!tile_active || brk);

  assign tile_in.ready = (state == ST_IDLE) && chunk.settled;
  assign in_take       = tile_in.valid && tile_in.ready;

  // sequencer and tile control
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      visit_count    <= '0;
      turn_index     <= '0;
      lead_count     <= '0;
      marker_latched <= 1'b0;
      tile_active    <= 1'b0;
      tile_tag       <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_take) begin
            if (tile_in.mode == MODE_LOAD) begin
              turn_index     <= '0;
              lead_count     <= '0;
              marker_latched <= 1'b0;
              tile_active    <= 1'b1;
            end else begin
              state       <= ST_RUN;
              visit_count <= '0;
            end
          end
        end
        ST_RUN: begin
          if (visit_fire) begin
            visit_count    <= visit_count + VISIT_W'(1);
            turn_index     <= idx_next;
            lead_count     <= lead_next;
            marker_latched <= latched_next;
            if (brk && done) begin
              tile_active <= 1'b0;
              tile_tag    <= tile_tag + TAG_W'(1);
            end
          end
          if (emit) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // tile payload and stream positions
  always_ff @(posedge clk) begin
    if (in_take && (tile_in.mode == MODE_LOAD)) begin
      tile_bytes       <= tile_in.tile_length;
      tile_offset_base <= tile_in.byte_offset;
      tile_substream   <= tile_in.substream;
      marker_allowed   <= tile_in.send_marker;
      for (int i = 0; i < MAX_STREAMS; i++) begin
        stream_position[i] <= '0;
      end
      stream_fin <= {MAX_STREAMS{tile_in.tile_length == '0}};
    end else if (visit_fire) begin
      stream_position[idx] <= end_pos;
      stream_fin[idx]      <= clamp;
    end
  end

  // output register fill and drain
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (emit) begin
      out_full <= 1'b1;
    end else if (pkt_out.ready) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      if (!tile_active) begin
        pkt_out.packet_valid    <= 1'b0;
        pkt_out.packet_offset   <= '0;
        pkt_out.payload_start   <= '0;
        pkt_out.payload_length  <= '0;
        pkt_out.marker          <= 1'b0;
        pkt_out.copies          <= '0;
        pkt_out.header_tag_word <= '0;
        pkt_out.tile_done       <= 1'b0;
      end else begin
        pkt_out.packet_valid    <= 1'b1;
        pkt_out.packet_offset   <= OFS_W'(start) + OFS_W'(tile_offset_base);
        pkt_out.payload_start   <= start;
        pkt_out.payload_length  <= dl;
        pkt_out.marker          <= latched_next;
        pkt_out.copies          <= (latched_next && redundancy_mode) ? COPIES_MARKED
                                                                     : COPIES_SINGLE;
        pkt_out.header_tag_word <= {tile_substream, tile_tag};
        pkt_out.tile_done       <= done;
      end
    end
  end

  assign pkt_out.valid = out_full;

  // checks
  a_tag_on_done: assert property (@(posedge clk) disable iff (rst)
    (visit_fire && brk && done) |=> (!tile_active && (tile_tag == $past(tile_tag) + TAG_W'(1))))
    else $error("tile end did not advance tag or clear tile");

  a_start_in_tile: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_RUN) && tile_active) |-> (start <= tile_bytes))
    else $error("stream position beyond tile end");

  a_turn_range: assert property (@(posedge clk) disable iff (rst)
    (int'(turn_index) < MAX_STREAMS))
    else $error("turn index out of range");

  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    (pkt_out.valid && !pkt_out.packet_valid) |->
      ((pkt_out.payload_length == '0) && !pkt_out.tile_done))
    else $error("result without tile carries a packet");

endmodule

### bench/tb_video_tile_packet_segmenter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_video_tile_packet_segmenter
// Self-checking bench for the tile packet segmenter. Loads tiles and requests
// packets under several mtu, multiplication and copy stream settings, predicts
// every descriptor in a scoreboard and compares it field by field.
// ----------------------------------------------------------------------------
module tb_video_tile_packet_segmenter;
  import vtps_pkg::*;

  localparam int  ITEM_TARGET  = 1950;
  localparam int  CYCLE_LIMIT  = 1000000;
  localparam int  VISIT_LIMIT  = 64;
  localparam int  IDLE_PCT     = 19;
  localparam int  HOLD_CYCLES  = 400;
  localparam int  SETTLE_WAIT  = 8;
  localparam int  DRAIN_WAIT   = 20;
  localparam int  PHASE_ITEMS  = 150;
  localparam longint unsigned TAG_MASK = 64'h3fffff;

  typedef struct packed {
    logic             mode;
    logic [LEN_W-1:0] tile_length;
    logic [LEN_W-1:0] byte_offset;
    logic [SUB_W-1:0] substream;
    logic             send_marker;
  } tile_item_t;

  typedef struct packed {
    logic                packet_valid;
    logic [OFS_W-1:0]    packet_offset;
    logic [LEN_W-1:0]    payload_start;
    logic [PLEN_W-1:0]   payload_length;
    logic                marker;
    logic [COPIES_W-1:0] copies;
    logic [HDR_W-1:0]    header_tag_word;
    logic                tile_done;
  } packet_desc_t;

  // predicts descriptors from accepted items and checks arriving ones
  class tile_packet_scoreboard;
    logic [MTU_W-1:0] mtu_bytes;
    logic             multiply;
    logic [CS_W-1:0]  copy_streams;

    longint unsigned  stream_pos[DEF_MAX_STREAMS];
    int               turn;
    int               lead;
    longint unsigned  tile_len;
    longint unsigned  tile_base;
    longint unsigned  tile_sub;
    bit               marker_ok;
    bit               marker_set;
    bit               tile_live;
    longint unsigned  tile_tag;

    packet_desc_t     expected_q[$];
    int               errors;
    int               checked;

    function new();
      mtu_bytes    = MTU_RESET;
      multiply     = 1'b0;
      copy_streams = COPIES_RESET;
      foreach (stream_pos[i]) stream_pos[i] = 0;
      turn       = 0;
      lead       = 0;
      tile_len   = 0;
      tile_base  = 0;
      tile_sub   = 0;
      marker_ok  = 0;
      marker_set = 0;
      tile_live  = 0;
      tile_tag   = 0;
      errors     = 0;
      checked    = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_MTU_BYTES:       mtu_bytes    = data[MTU_W-1:0];
        CFG_REDUNDANCY_MODE: multiply     = data[0];
        CFG_COPY_STREAMS:    copy_streams = data[CS_W-1:0];
        default: ;
      endcase
    endfunction

    // payload bytes per packet, never below one alignment unit
    function longint unsigned chunk_bytes();
      longint unsigned avail;
      longint unsigned p;
      avail = (mtu_bytes > DEF_HEADER_BYTES) ?
              64'(mtu_bytes) - 64'(DEF_HEADER_BYTES) : 64'(0);
      p = (avail / DEF_PAYLOAD_ALIGN) * DEF_PAYLOAD_ALIGN;
      return (p != 0) ? p : 64'(DEF_PAYLOAD_ALIGN);
    endfunction

    function int active_streams();
      if (!multiply || copy_streams == 0) return 1;
      return (copy_streams > DEF_MAX_STREAMS) ? DEF_MAX_STREAMS : int'(copy_streams);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_item(tile_item_t it);
      packet_desc_t    exp;
      longint unsigned p;
      longint unsigned start;
      longint unsigned fin;
      longint unsigned dl;
      int              k;
      int              idx;
      bit              done;
      // load: fresh positions, no descriptor
      if (it.mode == MODE_LOAD) begin
        tile_len  = 64'(it.tile_length);
        tile_base = 64'(it.byte_offset);
        tile_sub  = 64'(it.substream);
        marker_ok = it.send_marker;
        foreach (stream_pos[i]) stream_pos[i] = 0;
        turn       = 0;
        lead       = 0;
        marker_set = 0;
        tile_live  = 1;
        return;
      end
      exp = '0;
      if (!tile_live) begin
        expected_q.push_back(exp);
        return;
      end
      k     = active_streams();
      p     = chunk_bytes();
      start = 0;
      dl    = 0;
      done  = 0;
      // visit streams until one yields bytes or the tile ends
      for (int n = 0; n < VISIT_LIMIT; n++) begin
        idx   = (turn < k) ? turn : 0;
        start = stream_pos[idx];
        fin   = start + p;
        if (fin >= tile_len) begin
          if (marker_ok) marker_set = 1;
          fin = tile_len;
        end
        if (fin < start) fin = start;
        dl = fin - start;
        stream_pos[idx] = fin;
        if (lead < LEAD_MAX) lead++;
        if (idx != 0 || lead + 1 >= k) idx = (idx + 1) % k;
        turn = idx;
        done = stream_pos[k-1] >= tile_len;
        if (dl != 0 || done) break;
      end
      exp.packet_valid    = 1'b1;
      exp.packet_offset   = OFS_W'(start + tile_base);
      exp.payload_start   = LEN_W'(start);
      exp.payload_length  = PLEN_W'(dl);
      exp.marker          = marker_set;
      exp.copies          = (marker_set && multiply) ? COPIES_MARKED : COPIES_SINGLE;
      exp.header_tag_word = HDR_W'((tile_sub << TAG_W) | (tile_tag & TAG_MASK));
      exp.tile_done       = done;
      expected_q.push_back(exp);
      if (done) begin
        tile_live = 0;
        tile_tag  = (tile_tag + 1) & TAG_MASK;
      end
    endfunction

    task report_mismatch(string msg);
      errors++;
      $display("mismatch: %s", msg);
    endtask

    task check_result(packet_desc_t got);
      packet_desc_t exp;
      string        bad;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("descriptor with nothing expected: %h", got));
        return;
      end
      exp = expected_q.pop_front();
      bad = "";
      if (got.packet_valid !== exp.packet_valid) bad = {bad, " packet_valid"};
      if (got.packet_offset !== exp.packet_offset) bad = {bad, " packet_offset"};
      if (got.payload_start !== exp.payload_start) bad = {bad, " payload_start"};
      if (got.payload_length !== exp.payload_length) bad = {bad, " payload_length"};
      if (got.marker !== exp.marker) bad = {bad, " marker"};
      if (got.copies !== exp.copies) bad = {bad, " copies"};
      if (got.header_tag_word !== exp.header_tag_word) bad = {bad, " header_tag_word"};
      if (got.tile_done !== exp.tile_done) bad = {bad, " tile_done"};
      if (bad != "")
        report_mismatch($sformatf("descriptor %0d wrong:%s got %h exp %h",
                                  checked, bad, got, exp));
      checked++;
    endtask
  endclass

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  vtps_in_if  tile_in_bus ();
  vtps_out_if pkt_out_bus ();

  video_tile_packet_segmenter u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .tile_in   (tile_in_bus),
    .pkt_out   (pkt_out_bus)
  );

  tile_packet_scoreboard sb;
  packet_desc_t          seen_pkt;
  bit                    no_idle;
  int                    hold_req;
  int                    hold_seen   = 0;
  int                    hold_left   = 0;
  int                    n_items;
  int                    cycle_count = 0;

  always #10 clk = ~clk;

  // receiver: random stalls, long hold-offs on request, result checking
  always @(posedge clk) begin
    if (rst) begin
      pkt_out_bus.ready <= 1'b0;
    end else begin
      if (pkt_out_bus.valid && pkt_out_bus.ready) begin
        seen_pkt.packet_valid    = pkt_out_bus.packet_valid;
        seen_pkt.packet_offset   = pkt_out_bus.packet_offset;
        seen_pkt.payload_start   = pkt_out_bus.payload_start;
        seen_pkt.payload_length  = pkt_out_bus.payload_length;
        seen_pkt.marker          = pkt_out_bus.marker;
        seen_pkt.copies          = pkt_out_bus.copies;
        seen_pkt.header_tag_word = pkt_out_bus.header_tag_word;
        seen_pkt.tile_done       = pkt_out_bus.tile_done;
        sb.check_result(seen_pkt);
      end
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        pkt_out_bus.ready <= 1'b0;
      end else begin
        pkt_out_bus.ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL video_tile_packet_segmenter");
      $finish;
    end
  end

  // offer one item, with random gaps, and note it once accepted
  task automatic send_item(tile_item_t it);
    if (!no_idle) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        tile_in_bus.valid <= 1'b0;
        @(posedge clk);
      end
    end
    tile_in_bus.valid           <= 1'b1;
    tile_in_bus.mode            <= it.mode;
    tile_in_bus.tile_length     <= it.tile_length;
    tile_in_bus.byte_offset     <= it.byte_offset;
    tile_in_bus.substream       <= it.substream;
    tile_in_bus.send_marker     <= it.send_marker;
    do @(posedge clk); while (!tile_in_bus.ready);
    sb.note_item(it);
    n_items++;
  endtask

  function automatic tile_item_t load_item(int unsigned len, int unsigned ofs,
                                           int unsigned sub, bit mk);
    tile_item_t it;
    it.mode            = MODE_LOAD;
    it.tile_length     = LEN_W'(len);
    it.byte_offset     = LEN_W'(ofs);
    it.substream       = SUB_W'(sub);
    it.send_marker     = mk;
    return it;
  endfunction

  // request fields other than mode carry random junk
  function automatic tile_item_t request_item();
    tile_item_t it;
    it      = load_item($urandom, $urandom, $urandom, 1'($urandom_range(0, 1)));
    it.mode = MODE_REQUEST;
    return it;
  endfunction

  // wait until every descriptor is back and the block has settled
  task automatic wait_quiet();
    tile_in_bus.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  task automatic program_regs(int unsigned mtu, bit mult, int unsigned streams);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MTU_BYTES;
    cfg_data  <= CFG_DATA_W'(mtu);
    @(posedge clk);
    sb.write_reg(CFG_MTU_BYTES, CFG_DATA_W'(mtu));
    cfg_index <= CFG_REDUNDANCY_MODE;
    cfg_data  <= CFG_DATA_W'(mult);
    @(posedge clk);
    sb.write_reg(CFG_REDUNDANCY_MODE, CFG_DATA_W'(mult));
    cfg_index <= CFG_COPY_STREAMS;
    cfg_data  <= CFG_DATA_W'(streams);
    @(posedge clk);
    sb.write_reg(CFG_COPY_STREAMS, CFG_DATA_W'(streams));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // one tile: load, then request until done (or abandon early)
  task automatic run_tile();
    tile_item_t      it;
    longint unsigned p;
    longint unsigned len;
    int              cap;
    int              reqs;
    p = sb.chunk_bytes();
    case ($urandom_range(0, 9))
      0:       len = 0;
      1:       len = 64'($urandom_range(1, int'(p)));
      2:       len = p * $urandom_range(1, 4);
      3:       len = 64'({$urandom} & 32'h0fffffff);
      4:       len = 64'($urandom_range(1, 8));
      default: len = 64'($urandom_range(1, int'(4 * p)));
    endcase
    it  = load_item(int'(len), $urandom, $urandom, 1'($urandom_range(0, 1)));
    cap = (len > 16 * p || $urandom_range(0, 7) == 0) ? $urandom_range(1, 4) : 90;
    send_item(it);
    reqs = 0;
    while (sb.tile_live && reqs < cap) begin
      send_item(request_item());
      reqs++;
    end
    // now and then ask again once the tile is finished
    if (!sb.tile_live && $urandom_range(0, 7) == 0) send_item(request_item());
  endtask

  task automatic directed_items();
    // request before any load
    send_item(request_item());
    // empty tile with the marker allowed, then a request on an idle block
    send_item(load_item(0, 28'hfffffff, 10'h3ff, 1'b1));
    send_item(request_item());
    send_item(request_item());
    // two full chunks plus a short tail at the reset mtu
    send_item(load_item(2880, 0, 0, 1'b0));
    send_item(request_item());
    send_item(request_item());
    // largest tile, abandoned by a new load
    send_item(load_item(28'hfffffff, 28'hfffffff, 10'h155, 1'b1));
    send_item(request_item());
    send_item(request_item());
    send_item(load_item(1, 28'h5555555, 10'h2aa, 1'b1));
    send_item(request_item());
    // 49 bytes past a chunk boundary at the reset mtu
    send_item(load_item(1441, 28'haaaaaaa, 10'h0ff, 1'b1));
    send_item(request_item());
    send_item(request_item());
    send_item(request_item());
    // load right after another load
    send_item(load_item(100, 28'h0000001, 10'h300, 1'b0));
    send_item(load_item(1500, 28'h8000000, 10'h001, 1'b1));
    send_item(request_item());
    send_item(request_item());
  endtask

  int unsigned set_mtu[5]     = '{112, 9000, 100, 576, 1500};
  bit          set_mult[5]    = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0};
  int unsigned set_streams[5] = '{10, 1, 0, 15, 7};

  initial begin
    int phase;
    int phase_end;
    clk                         = 1'b0;
    rst                         = 1'b1;
    cfg_we                      = 1'b0;
    cfg_index                   = CFG_MTU_BYTES;
    cfg_data                    = '0;
    tile_in_bus.valid           = 1'b0;
    tile_in_bus.mode            = MODE_LOAD;
    tile_in_bus.tile_length     = '0;
    tile_in_bus.byte_offset     = '0;
    tile_in_bus.substream       = '0;
    tile_in_bus.send_marker     = 1'b0;
    no_idle                     = 1'b0;
    hold_req                    = 0;
    n_items                     = 0;
    sb = new();

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    directed_items();

    // phases: fixed corner settings first, then random ones
    phase = 0;
    while (n_items < ITEM_TARGET) begin
      wait_quiet();
      if (phase < 5)
        program_regs(set_mtu[phase], set_mult[phase], set_streams[phase]);
      else
        program_regs($urandom_range(112, 9000), 1'($urandom_range(0, 1)),
                     $urandom_range(0, 15));
      no_idle = (phase == 2);
      if (phase == 1 || phase == 6) hold_req++;
      phase_end = n_items + PHASE_ITEMS;
      while (n_items < phase_end) begin
        if ($urandom_range(0, 9) == 0) begin
          if ($urandom_range(0, 1) == 0)
            send_item(request_item());
          else
            send_item(load_item($urandom, $urandom, $urandom,
                                1'($urandom_range(0, 1))));
        end else begin
          run_tile();
        end
      end
      phase++;
    end

    // drain
    tile_in_bus.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.errors == 0) begin
      $display("PASS video_tile_packet_segmenter");
    end else begin
      $display("FAIL video_tile_packet_segmenter");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/vtps_pkg.sv
rtl/core/vtps_in_if.sv
rtl/core/vtps_out_if.sv
rtl/core/vtps_chunk.sv
rtl/core/video_tile_packet_segmenter.sv
bench/tb_video_tile_packet_segmenter.sv
